@@ rtl/core/dfg_pkg.sv @@
// Shared types, codes and constants for the decaying field grid.
// No dependencies; every other file in rtl/core uses it by scoped names.
`default_nettype none

package dfg_pkg;

    localparam int MAX_COLUMNS_DEF = 128;
    localparam int MAX_ROWS_DEF    = 128;

    localparam int ACTION_W   = 3;
    localparam int COORD_W    = 8;
    localparam int CELL_W     = 8;
    localparam int DIM_W      = 8;
    localparam int RATE_W     = 12;
    localparam int FRAC_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [DIM_W-1:0]  GRID_WIDTH_RST  = 8'd128;
    localparam logic [DIM_W-1:0]  GRID_HEIGHT_RST = 8'd128;
    localparam logic [RATE_W-1:0] DECAY_RATE_RST  = 12'd16;
    localparam logic [CELL_W-1:0] CELL_MAX        = 8'hFF;

    typedef enum logic [ACTION_W-1:0] {
        ACT_EMIT  = 3'd0,
        ACT_READ  = 3'd1,
        ACT_WRITE = 3'd2,
        ACT_CLEAR = 3'd3,
        ACT_DECAY = 3'd4
    } action_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_DECAY_RATE  = 2'd2
    } cfg_index_e;

    typedef enum logic [1:0] {
        ALU_ZERO    = 2'd0,
        ALU_ADD_SAT = 2'd1,
        ALU_DECAY   = 2'd2
    } alu_op_e;

    typedef enum logic [2:0] {
        ST_INIT      = 3'd0,
        ST_IDLE      = 3'd1,
        ST_SETUP     = 3'd2,
        ST_SWEEP     = 3'd3,
        ST_DRAIN     = 3'd4,
        ST_READ_WAIT = 3'd5,
        ST_FINISH    = 3'd6
    } state_e;

    typedef struct packed {
        logic [DIM_W-1:0]  grid_width;
        logic [DIM_W-1:0]  grid_height;
        logic [RATE_W-1:0] decay_rate;
    } cfg_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [COORD_W-1:0]  pos_x;
        logic [COORD_W-1:0]  pos_y;
        logic [COORD_W-1:0]  reach;
        logic [CELL_W-1:0]   level;
    } item_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        alu_op_e           alu_op;
        logic [CELL_W-1:0] operand;
    } unit_ctl_t;

    typedef struct packed {
        logic              valid;
        logic [CELL_W-1:0] value;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/core/dfg_ifs.sv @@
// Valid/ready channel interfaces for the command and response sides.
// Depends on dfg_pkg for field widths.
`default_nettype none

interface dfg_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [dfg_pkg::ACTION_W-1:0]  action;
    logic [dfg_pkg::COORD_W-1:0]   pos_x;
    logic [dfg_pkg::COORD_W-1:0]   pos_y;
    logic [dfg_pkg::COORD_W-1:0]   reach;
    logic [dfg_pkg::CELL_W-1:0]    level;

    modport source (output valid, action, pos_x, pos_y, reach, level, input ready);
    modport sink   (input valid, action, pos_x, pos_y, reach, level, output ready);
endinterface

interface dfg_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [dfg_pkg::CELL_W-1:0]  read_value;

    modport source (output valid, read_value, input ready);
    modport sink   (input valid, read_value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/decaying_field_grid.sv @@
// Decaying field grid: 8-bit cells updated by emit, read, write, clear, decay.
// Flow: SETUP issues a one-cell read or write, and an in-grid read waits in READ_WAIT;
// a non-empty emit or clear/decay region runs SWEEP, then DRAIN; all items end in FINISH.
// Throughput: one item at a time; the next can be taken while rsp.valid still waits for
// the sink; a sweep moves one cell per cycle through the shared unit.
// Reset: config 128 x 128, rate 1.0, then a pass that zeroes all 2**(COL_W+ROW_W) cells.
`default_nettype none

module decaying_field_grid #(
    parameter int MAX_COLUMNS = dfg_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = dfg_pkg::MAX_ROWS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    dfg_cmd_if.sink                             cmd,
    dfg_rsp_if.source                           rsp,
    input  wire logic                           cfg_we,
    input  wire logic [dfg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dfg_pkg::CFG_DATA_W-1:0] cfg_data
);

    // address is {column, row}; each coordinate gets the bits its maximum needs
    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW    = COL_W + ROW_W;

    dfg_pkg::cfg_t      cfg_reg, cfg_next;
    dfg_pkg::item_t     cmd_item;
    dfg_pkg::unit_ctl_t ctl;
    dfg_pkg::res_t      fin;

    logic [AW-1:0]                rd_addr, wr_addr;
    logic [dfg_pkg::CELL_W-1:0]   wr_data, mem_rdata, alu_result;
    logic                         fin_ok;
    logic                         out_valid_reg, out_valid_next;
    logic [dfg_pkg::CELL_W-1:0]   out_value_reg, out_value_next;

    // Configuration writes; an index past the list is dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                dfg_pkg::CFG_GRID_WIDTH:
                    cfg_next.grid_width = cfg_data[dfg_pkg::DIM_W-1:0];
                dfg_pkg::CFG_GRID_HEIGHT:
                    cfg_next.grid_height = cfg_data[dfg_pkg::DIM_W-1:0];
                dfg_pkg::CFG_DECAY_RATE:
                    cfg_next.decay_rate = cfg_data[dfg_pkg::RATE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_width  <= dfg_pkg::GRID_WIDTH_RST;
            cfg_reg.grid_height <= dfg_pkg::GRID_HEIGHT_RST;
            cfg_reg.decay_rate  <= dfg_pkg::DECAY_RATE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Pack the command channel into one item.
    assign cmd_item.action = cmd.action;
    assign cmd_item.pos_x  = cmd.pos_x;
    assign cmd_item.pos_y  = cmd.pos_y;
    assign cmd_item.reach  = cmd.reach;
    assign cmd_item.level  = cmd.level;

    dfg_seq #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd.valid),
        .cmd_item   (cmd_item),
        .cmd_ready  (cmd.ready),
        .cfg        (cfg_reg),
        .ctl        (ctl),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .mem_rdata  (mem_rdata),
        .alu_result (alu_result),
        .fin_ok     (fin_ok),
        .fin        (fin)
    );

    dfg_mem #(
        .AW (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (mem_rdata),
        .wr_en   (ctl.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Shared update unit works on the cell just read during a sweep.
    dfg_alu u_alu (
        .op         (ctl.alu_op),
        .cell_value (mem_rdata),
        .operand    (ctl.operand),
        .rate       (cfg_reg.decay_rate),
        .result     (alu_result)
    );

    // Output register: hold a finished item until the sink takes it, so the
    // sequencer can go back to idle and accept the next command meanwhile.
    assign fin_ok = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        if (fin.valid && fin_ok)
        begin
            out_valid_next = 1'b1;
            out_value_next = fin.value;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = out_value_reg;

endmodule

`default_nettype wire

@@ rtl/core/dfg_mem.sv @@
// Cell memory: one write port and one read port with registered read data.
// Depends on dfg_pkg for the cell width.
`default_nettype none

module dfg_mem #(
    parameter int AW = 14
) (
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [AW-1:0]              rd_addr,
    output logic      [dfg_pkg::CELL_W-1:0] rd_data,
    input  wire logic                       wr_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [dfg_pkg::CELL_W-1:0] wr_data
);

    logic [dfg_pkg::CELL_W-1:0] mem_reg [2**AW];
    logic [dfg_pkg::CELL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/dfg_alu.sv @@
// Shared cell update unit: saturating add, fixed-point decay, or zero.
// Depends on dfg_pkg for the operation codes and widths.
`default_nettype none

module dfg_alu (
    input  wire dfg_pkg::alu_op_e           op,
    input  wire logic [dfg_pkg::CELL_W-1:0] cell_value,
    input  wire logic [dfg_pkg::CELL_W-1:0] operand,
    input  wire logic [dfg_pkg::RATE_W-1:0] rate,
    output logic      [dfg_pkg::CELL_W-1:0] result
);

    logic [dfg_pkg::CELL_W:0]   sum;
    logic [dfg_pkg::RATE_W-1:0] scaled;
    logic [dfg_pkg::RATE_W-1:0] diff;

    always_comb
    begin
        sum    = {1'b0, cell_value} + {1'b0, operand};
        // cell in 8.4 fixed point; clamp at zero, then drop the fraction
        scaled = {cell_value, {dfg_pkg::FRAC_W{1'b0}}};
        diff   = (scaled > rate) ? (scaled - rate) : '0;
        case (op)
            dfg_pkg::ALU_ADD_SAT: result = sum[dfg_pkg::CELL_W] ? dfg_pkg::CELL_MAX
                                                                : sum[dfg_pkg::CELL_W-1:0];
            dfg_pkg::ALU_DECAY:   result = diff[dfg_pkg::RATE_W-1:dfg_pkg::FRAC_W];
            dfg_pkg::ALU_ZERO:    result = '0;
            default:              result = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/dfg_seq.sv @@
// Sequencer: startup clearing pass, region bounds, cell sweep with a
// read-modify-write pipeline, single-cell read and write. Depends on dfg_pkg.
`default_nettype none

module dfg_seq #(
    parameter int MAX_COLUMNS = dfg_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = dfg_pkg::MAX_ROWS_DEF,
    localparam int COL_W      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
    localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int AW         = COL_W + ROW_W
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cmd_valid,
    input  wire dfg_pkg::item_t             cmd_item,
    output logic                            cmd_ready,
    input  wire dfg_pkg::cfg_t              cfg,
    output dfg_pkg::unit_ctl_t              ctl,
    output logic      [AW-1:0]              rd_addr,
    output logic      [AW-1:0]              wr_addr,
    output logic      [dfg_pkg::CELL_W-1:0] wr_data,
    input  wire logic [dfg_pkg::CELL_W-1:0] mem_rdata,
    input  wire logic [dfg_pkg::CELL_W-1:0] alu_result,
    input  wire logic                       fin_ok,
    output dfg_pkg::res_t                   fin
);

    localparam int BW = dfg_pkg::COORD_W + 1;

    dfg_pkg::state_e state_reg, state_next;
    dfg_pkg::item_t  item_reg, item_next;

    logic [BW-1:0]                x1_reg, x1_next;
    logic [BW-1:0]                y0_reg, y0_next;
    logic [BW-1:0]                y1_reg, y1_next;
    logic [dfg_pkg::COORD_W-1:0]  i_reg, i_next;
    logic [dfg_pkg::COORD_W-1:0]  j_reg, j_next;
    logic                         wr_pend_reg, wr_pend_next;
    logic [AW-1:0]                wr_addr_reg, wr_addr_next;
    logic [AW-1:0]                init_cnt_reg, init_cnt_next;
    logic [dfg_pkg::CELL_W-1:0]   res_reg, res_next;

    logic [BW-1:0] cols, rows;
    logic [BW-1:0] xz, yz, rz, xs, ys;
    logic [BW-1:0] xlo, xhi, ylo, yhi;
    logic          in_grid, region_empty, is_sweep;
    logic          row_end, col_end;

    function automatic logic [AW-1:0] cell_addr(
        input logic [dfg_pkg::COORD_W-1:0] cx,
        input logic [dfg_pkg::COORD_W-1:0] cy
    );
        return {cx[COL_W-1:0], cy[ROW_W-1:0]};
    endfunction

    // grid in use and region bounds for the held item
    always_comb
    begin
        cols = ({1'b0, cfg.grid_width} < BW'(MAX_COLUMNS)) ? {1'b0, cfg.grid_width}
                                                          : BW'(MAX_COLUMNS);
        rows = ({1'b0, cfg.grid_height} < BW'(MAX_ROWS)) ? {1'b0, cfg.grid_height}
                                                        : BW'(MAX_ROWS);
        xz = {1'b0, item_reg.pos_x};
        yz = {1'b0, item_reg.pos_y};
        rz = {1'b0, item_reg.reach};
        xs = xz + rz;
        ys = yz + rz;
        in_grid = (xz < cols) && (yz < rows);
        is_sweep = 1'b1;
        case (item_reg.action)
            dfg_pkg::ACT_EMIT:
            begin
                xlo = (xz >= rz) ? (xz - rz) : '0;
                ylo = (yz >= rz) ? (yz - rz) : '0;
                xhi = (xs < cols) ? xs : cols;
                yhi = (ys < rows) ? ys : rows;
            end
            dfg_pkg::ACT_CLEAR, dfg_pkg::ACT_DECAY:
            begin
                xlo = '0;
                ylo = '0;
                xhi = cols;
                yhi = rows;
            end
            default:
            begin
                xlo = '0;
                ylo = '0;
                xhi = '0;
                yhi = '0;
                is_sweep = 1'b0;
            end
        endcase
        region_empty = (xlo >= xhi) || (ylo >= yhi);
        row_end = (({1'b0, j_reg} + BW'(1)) == y1_reg);
        col_end = (({1'b0, i_reg} + BW'(1)) == x1_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dfg_pkg::ST_INIT:
                if (init_cnt_reg == '1)
                begin
                    state_next = dfg_pkg::ST_IDLE;
                end
            dfg_pkg::ST_IDLE:
                if (cmd_valid)
                begin
                    state_next = dfg_pkg::ST_SETUP;
                end
            dfg_pkg::ST_SETUP:
                if (is_sweep && !region_empty)
                begin
                    state_next = dfg_pkg::ST_SWEEP;
                end
                else if ((item_reg.action == dfg_pkg::ACT_READ) && in_grid)
                begin
                    state_next = dfg_pkg::ST_READ_WAIT;
                end
                else
                begin
                    state_next = dfg_pkg::ST_FINISH;
                end
            dfg_pkg::ST_SWEEP:
                if (row_end && col_end)
                begin
                    state_next = dfg_pkg::ST_DRAIN;
                end
            dfg_pkg::ST_DRAIN:
                state_next = dfg_pkg::ST_FINISH;
            dfg_pkg::ST_READ_WAIT:
                state_next = dfg_pkg::ST_FINISH;
            dfg_pkg::ST_FINISH:
                if (fin_ok)
                begin
                    state_next = dfg_pkg::ST_IDLE;
                end
            default:
                state_next = dfg_pkg::ST_IDLE;
        endcase
    end

    // outputs toward memory, update unit and response side
    always_comb
    begin
        cmd_ready   = 1'b0;
        ctl.rd_en   = 1'b0;
        ctl.wr_en   = 1'b0;
        ctl.operand = item_reg.level;
        case (item_reg.action)
            dfg_pkg::ACT_EMIT:  ctl.alu_op = dfg_pkg::ALU_ADD_SAT;
            dfg_pkg::ACT_DECAY: ctl.alu_op = dfg_pkg::ALU_DECAY;
            default:            ctl.alu_op = dfg_pkg::ALU_ZERO;
        endcase
        rd_addr   = cell_addr(i_reg, j_reg);
        wr_addr   = wr_addr_reg;
        wr_data   = alu_result;
        fin.valid = 1'b0;
        fin.value = res_reg;
        case (state_reg)
            dfg_pkg::ST_INIT:
            begin
                ctl.wr_en = 1'b1;
                wr_addr   = init_cnt_reg;
                wr_data   = '0;
            end
            dfg_pkg::ST_IDLE:
                cmd_ready = 1'b1;
            dfg_pkg::ST_SETUP:
            begin
                rd_addr = cell_addr(item_reg.pos_x, item_reg.pos_y);
                wr_addr = cell_addr(item_reg.pos_x, item_reg.pos_y);
                wr_data = item_reg.level;
                ctl.rd_en = (item_reg.action == dfg_pkg::ACT_READ) && in_grid;
                ctl.wr_en = (item_reg.action == dfg_pkg::ACT_WRITE) && in_grid;
            end
            dfg_pkg::ST_SWEEP:
            begin
                ctl.rd_en = 1'b1;
                ctl.wr_en = wr_pend_reg;
            end
            dfg_pkg::ST_DRAIN:
                ctl.wr_en = wr_pend_reg;
            dfg_pkg::ST_FINISH:
                fin.valid = 1'b1;
            default:
                cmd_ready = 1'b0;
        endcase
    end

    // datapath registers
    always_comb
    begin
        item_next     = item_reg;
        x1_next       = x1_reg;
        y0_next       = y0_reg;
        y1_next       = y1_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        wr_pend_next  = 1'b0;
        wr_addr_next  = wr_addr_reg;
        init_cnt_next = init_cnt_reg;
        res_next      = res_reg;
        case (state_reg)
            dfg_pkg::ST_INIT:
                init_cnt_next = init_cnt_reg + AW'(1);
            dfg_pkg::ST_IDLE:
                if (cmd_valid)
                begin
                    item_next = cmd_item;
                end
            dfg_pkg::ST_SETUP:
            begin
                x1_next  = xhi;
                y0_next  = ylo;
                y1_next  = yhi;
                i_next   = xlo[dfg_pkg::COORD_W-1:0];
                j_next   = ylo[dfg_pkg::COORD_W-1:0];
                res_next = '0;
            end
            dfg_pkg::ST_SWEEP:
            begin
                // read this cell now, write it back next cycle
                wr_pend_next = 1'b1;
                wr_addr_next = cell_addr(i_reg, j_reg);
                if (row_end)
                begin
                    j_next = y0_reg[dfg_pkg::COORD_W-1:0];
                    i_next = i_reg + 8'd1;
                end
                else
                begin
                    j_next = j_reg + 8'd1;
                end
            end
            dfg_pkg::ST_READ_WAIT:
                res_next = mem_rdata;
            default:
                wr_pend_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dfg_pkg::ST_INIT;
            init_cnt_reg <= '0;
            wr_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            init_cnt_reg <= init_cnt_next;
            wr_pend_reg  <= wr_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        x1_reg      <= x1_next;
        y0_reg      <= y0_next;
        y1_reg      <= y1_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        wr_addr_reg <= wr_addr_next;
        res_reg     <= res_next;
    end

endmodule

`default_nettype wire
